// ===== hdl/bpt_pkg.sv =====
// Shared constants, types and encodings for the beacon presence table.
// Has no dependencies; the interfaces and the top level use it.
`default_nettype none

package bpt_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   // Field widths.
   localparam int OPCODE_W      = 2;
   localparam int ADDR_W        = 48;
   localparam int TIME_W        = 32;
   localparam int RSSI_W        = 8;
   localparam int ENTRY_COUNT_W = 5;
   localparam int PAIR_MODE_W   = 2;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNSEEN_TIMEOUT  = 2'd2;

   // Register reset values.
   localparam logic signed [RSSI_W-1:0] NEAR_THRESHOLD_RST  = -8'sd80;
   localparam logic signed [RSSI_W-1:0] CLOSE_THRESHOLD_RST = -8'sd50;
   localparam logic [TIME_W-1:0]        UNSEEN_TIMEOUT_RST  = 32'd30000;

   typedef enum logic [OPCODE_W-1:0] {
      OP_REPORT       = 2'd0,
      OP_AGE          = 2'd1,
      OP_LEARN_BEGIN  = 2'd2,
      OP_LEARN_FINISH = 2'd3
   } op_type;

   typedef enum logic [PAIR_MODE_W-1:0] {
      PAIR_OPEN  = 2'd0,
      PAIR_ADDR  = 2'd1,
      PAIR_EMPTY = 2'd2
   } pair_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY,
      S_SUM,
      S_DONE
   } seq_state_type;

endpackage

`default_nettype wire

// ===== hdl/bpt_intf.sv =====
// Valid/ready channel interfaces for requests, responses and register writes.
// Depends on bpt_pkg for the field widths.
`default_nettype none

interface bpt_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [bpt_pkg::OPCODE_W-1:0]         opcode;
   logic [bpt_pkg::TIME_W-1:0]           now_ms;
   logic [bpt_pkg::ADDR_W-1:0]           beacon_address;
   logic signed [bpt_pkg::RSSI_W-1:0]    beacon_strength;
   logic [bpt_pkg::TIME_W-1:0]           pause_ms;

   modport source (output valid, opcode, now_ms, beacon_address, beacon_strength,
                   pause_ms, input ready);
   modport sink   (input valid, opcode, now_ms, beacon_address, beacon_strength,
                   pause_ms, output ready);
endinterface

interface bpt_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 present;
   logic                                 close;
   logic [bpt_pkg::ENTRY_COUNT_W-1:0]    entry_count;
   logic [bpt_pkg::PAIR_MODE_W-1:0]      pair_mode;
   logic [bpt_pkg::ADDR_W-1:0]           pair_address;
   logic                                 learning;
   logic                                 dropped;

   modport source (output valid, present, close, entry_count, pair_mode, pair_address,
                   learning, dropped, input ready);
   modport sink   (input valid, present, close, entry_count, pair_mode, pair_address,
                   learning, dropped, output ready);
endinterface

interface bpt_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [bpt_pkg::CSR_IDX_W-1:0]        index;
   logic [bpt_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/beacon_presence_table.sv =====
// Beacon presence table: each request beat runs through two passes of the
// single entry-at-a-time sequencer, one that performs the operation and one
// that summarizes, before its response is loaded into the response register.
// A new request is accepted the cycle after the response is loaded, even if
// the previous response beat has not yet been taken. Synchronous reset clears
// the valid bits, pairing, learning flag, registers and handshake state.
`default_nettype none

module beacon_presence_table (
   input  wire logic   clock,
   input  wire logic   reset,
   bpt_req_if.sink     req_bus,
   bpt_rsp_if.source   rsp_bus,
   bpt_csr_if.sink     csr_bus
);

   // ------------------------------------------------------------------
   // Table storage. Only the valid bits are reset; the payload of an
   // entry is read only behind its valid bit.
   // ------------------------------------------------------------------
   logic                              valid_ff [bpt_pkg::TABLE_DEPTH];
   logic [bpt_pkg::ADDR_W-1:0]        tbl_addr_ff [bpt_pkg::TABLE_DEPTH];
   logic signed [bpt_pkg::RSSI_W-1:0] tbl_rssi_ff [bpt_pkg::TABLE_DEPTH];
   logic [bpt_pkg::TIME_W-1:0]        tbl_time_ff [bpt_pkg::TABLE_DEPTH];

   // Sequencer and pass index.
   bpt_pkg::seq_state_type      state_ff, state_in;
   logic [bpt_pkg::IDX_W-1:0]   idx_ff, idx_in;

   // Latched request beat.
   bpt_pkg::op_type                   op_ff;
   logic [bpt_pkg::TIME_W-1:0]        now_ff;
   logic [bpt_pkg::ADDR_W-1:0]        addr_ff;
   logic signed [bpt_pkg::RSSI_W-1:0] rssi_ff;
   logic [bpt_pkg::TIME_W-1:0]        pause_ff;

   // Configuration registers.
   logic signed [bpt_pkg::RSSI_W-1:0] near_ff, near_in;
   logic signed [bpt_pkg::RSSI_W-1:0] close_th_ff, close_th_in;
   logic [bpt_pkg::TIME_W-1:0]        timeout_ff, timeout_in;

   // Pairing state.
   bpt_pkg::pair_type           pair_mode_ff, pair_mode_in;
   logic [bpt_pkg::ADDR_W-1:0]  pair_addr_ff, pair_addr_in;
   logic                        learn_ff, learn_in;

   // Scan results of the operation pass.
   logic                              hit_ff, hit_in;
   logic [bpt_pkg::IDX_W-1:0]         hit_idx_ff, hit_idx_in;
   logic                              free_ff, free_in;
   logic [bpt_pkg::IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic                              best_ff, best_in;
   logic signed [bpt_pkg::RSSI_W-1:0] best_rssi_ff, best_rssi_in;
   logic [bpt_pkg::ADDR_W-1:0]        best_addr_ff, best_addr_in;

   // Summary pass accumulators.
   logic [bpt_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        close_ff, close_in;
   logic                        present_ff, present_in;
   logic                        dropped_ff, dropped_in;

   // Response register.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_load;
   logic                              rsp_present_ff;
   logic                              rsp_close_ff;
   logic [bpt_pkg::ENTRY_COUNT_W-1:0] rsp_count_ff;
   bpt_pkg::pair_type                 rsp_pair_mode_ff;
   logic [bpt_pkg::ADDR_W-1:0]        rsp_pair_addr_ff;
   logic                              rsp_learning_ff;
   logic                              rsp_dropped_ff;

   // Table write controls.
   logic                        tbl_we_addr;
   logic                        tbl_we_rssi;
   logic                        tbl_we_time;
   logic [bpt_pkg::IDX_W-1:0]   tbl_wr_idx;
   logic [bpt_pkg::TIME_W-1:0]  tbl_wr_time;
   logic                        vld_we;
   logic                        vld_wdata;

   // Shared datapath on the entry selected by the pass index.
   logic                              cur_valid;
   logic [bpt_pkg::ADDR_W-1:0]        cur_addr;
   logic signed [bpt_pkg::RSSI_W-1:0] cur_rssi;
   logic [bpt_pkg::TIME_W-1:0]        cur_time;
   logic [bpt_pkg::ADDR_W-1:0]        cmp_addr;
   logic                              addr_match;
   logic [bpt_pkg::TIME_W-1:0]        shifted_time;
   logic [bpt_pkg::TIME_W-1:0]        age_ms;
   logic                              expired;
   logic                              better;
   logic                              report_ok;
   logic                              req_fire;
   logic                              last_idx;

   assign req_bus.ready = (state_ff == bpt_pkg::S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign cur_valid = valid_ff[idx_ff];
   assign cur_addr  = tbl_addr_ff[idx_ff];
   assign cur_rssi  = tbl_rssi_ff[idx_ff];
   assign cur_time  = tbl_time_ff[idx_ff];
   assign last_idx  = (idx_ff == bpt_pkg::LAST_IDX);

   // One address comparator serves both passes: the request address while
   // the operation pass looks for a known entry, the paired address while
   // the summary pass checks presence.
   assign cmp_addr   = (state_ff == bpt_pkg::S_SUM) ? pair_addr_ff : addr_ff;
   assign addr_match = (cur_addr == cmp_addr);

   // Aging arithmetic: wrapping time shift and wrapping age.
   assign shifted_time = cur_time + pause_ff;
   assign age_ms       = now_ff - cur_time;
   assign expired      = (age_ms > timeout_ff);

   // Strongest entry wins; on equal strength the lower address wins.
   assign better = !best_ff || (cur_rssi > best_rssi_ff) ||
                   ((cur_rssi == best_rssi_ff) && (cur_addr < best_addr_ff));

   // A report counts only above the near threshold, and only from an
   // accepted source: anyone while learning or unpaired, else the partner.
   assign report_ok = (rssi_ff > near_ff) &&
                      (learn_ff || (pair_mode_ff == bpt_pkg::PAIR_OPEN) ||
                       ((pair_mode_ff == bpt_pkg::PAIR_ADDR) && (pair_addr_ff == addr_ff)));

   // ------------------------------------------------------------------
   // Configuration writes. Writes to an index past the register list
   // are taken and ignored.
   // ------------------------------------------------------------------
   always_comb begin
      near_in     = near_ff;
      close_th_in = close_th_ff;
      timeout_in  = timeout_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            bpt_pkg::CSR_NEAR_THRESHOLD: begin
               near_in = $signed(csr_bus.data[bpt_pkg::RSSI_W-1:0]);
            end
            bpt_pkg::CSR_CLOSE_THRESHOLD: begin
               close_th_in = $signed(csr_bus.data[bpt_pkg::RSSI_W-1:0]);
            end
            bpt_pkg::CSR_UNSEEN_TIMEOUT: begin
               timeout_in = csr_bus.data[bpt_pkg::TIME_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Sequencer: next state, pass bookkeeping and table write strobes.
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pair_mode_in  = pair_mode_ff;
      pair_addr_in  = pair_addr_ff;
      learn_in      = learn_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      best_in       = best_ff;
      best_rssi_in  = best_rssi_ff;
      best_addr_in  = best_addr_ff;
      cnt_in        = cnt_ff;
      close_in      = close_ff;
      present_in    = present_ff;
      dropped_in    = dropped_ff;
      rsp_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      tbl_we_addr   = 1'b0;
      tbl_we_rssi   = 1'b0;
      tbl_we_time   = 1'b0;
      tbl_wr_idx    = idx_ff;
      tbl_wr_time   = now_ff;
      vld_we        = 1'b0;
      vld_wdata     = 1'b0;

      case (state_ff)
         bpt_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in   = bpt_pkg::S_SCAN;
               idx_in     = '0;
               hit_in     = 1'b0;
               free_in    = 1'b0;
               best_in    = 1'b0;
               dropped_in = 1'b0;
            end
         end

         bpt_pkg::S_SCAN: begin
            case (op_ff)
               bpt_pkg::OP_REPORT: begin
                  if (cur_valid && addr_match && !hit_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = idx_ff;
                  end
                  if (!cur_valid && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = idx_ff;
                  end
               end
               bpt_pkg::OP_AGE: begin
                  if (cur_valid) begin
                     if (pause_ff != '0) begin
                        tbl_we_time = 1'b1;
                        tbl_wr_time = shifted_time;
                     end else if (expired) begin
                        vld_we    = 1'b1;
                        vld_wdata = 1'b0;
                     end
                  end
               end
               bpt_pkg::OP_LEARN_FINISH: begin
                  if (cur_valid && better) begin
                     best_in      = 1'b1;
                     best_rssi_in = cur_rssi;
                     best_addr_in = cur_addr;
                  end
               end
               default: begin
               end
            endcase
            if (last_idx) begin
               state_in = bpt_pkg::S_APPLY;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         bpt_pkg::S_APPLY: begin
            case (op_ff)
               bpt_pkg::OP_REPORT: begin
                  if (report_ok) begin
                     if (hit_ff) begin
                        tbl_wr_idx  = hit_idx_ff;
                        tbl_we_rssi = 1'b1;
                        tbl_we_time = 1'b1;
                     end else if (free_ff) begin
                        tbl_wr_idx  = free_idx_ff;
                        tbl_we_addr = 1'b1;
                        tbl_we_rssi = 1'b1;
                        tbl_we_time = 1'b1;
                        vld_we      = 1'b1;
                        vld_wdata   = 1'b1;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
               end
               bpt_pkg::OP_LEARN_BEGIN: begin
                  learn_in = 1'b1;
               end
               bpt_pkg::OP_LEARN_FINISH: begin
                  if (learn_ff) begin
                     learn_in = 1'b0;
                     if (best_ff) begin
                        pair_mode_in = bpt_pkg::PAIR_ADDR;
                        pair_addr_in = best_addr_ff;
                     end else begin
                        pair_mode_in = bpt_pkg::PAIR_EMPTY;
                        pair_addr_in = '0;
                     end
                  end
               end
               default: begin
               end
            endcase
            state_in   = bpt_pkg::S_SUM;
            idx_in     = '0;
            cnt_in     = '0;
            close_in   = 1'b0;
            present_in = 1'b0;
         end

         bpt_pkg::S_SUM: begin
            if (cur_valid) begin
               cnt_in = cnt_ff + 1'b1;
               if (cur_rssi >= close_th_ff) begin
                  close_in = 1'b1;
               end
               if (addr_match && (pair_mode_ff == bpt_pkg::PAIR_ADDR)) begin
                  present_in = 1'b1;
               end
            end
            if (last_idx) begin
               state_in = bpt_pkg::S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         bpt_pkg::S_DONE: begin
            // Hand the summary to the response register once it is free.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = bpt_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = bpt_pkg::S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Control registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpt_pkg::S_IDLE;
         idx_ff       <= '0;
         near_ff      <= bpt_pkg::NEAR_THRESHOLD_RST;
         close_th_ff  <= bpt_pkg::CLOSE_THRESHOLD_RST;
         timeout_ff   <= bpt_pkg::UNSEEN_TIMEOUT_RST;
         pair_mode_ff <= bpt_pkg::PAIR_OPEN;
         pair_addr_ff <= '0;
         learn_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         near_ff      <= near_in;
         close_th_ff  <= close_th_in;
         timeout_ff   <= timeout_in;
         pair_mode_ff <= pair_mode_in;
         pair_addr_ff <= pair_addr_in;
         learn_ff     <= learn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Pass bookkeeping and the latched request; each is set up before use.
   always_ff @(posedge clock) begin
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      best_ff      <= best_in;
      best_rssi_ff <= best_rssi_in;
      best_addr_ff <= best_addr_in;
      cnt_ff       <= cnt_in;
      close_ff     <= close_in;
      present_ff   <= present_in;
      dropped_ff   <= dropped_in;
      if (req_fire) begin
         op_ff    <= bpt_pkg::op_type'(req_bus.opcode);
         now_ff   <= req_bus.now_ms;
         addr_ff  <= req_bus.beacon_address;
         rssi_ff  <= req_bus.beacon_strength;
         pause_ff <= req_bus.pause_ms;
      end
   end

   // ------------------------------------------------------------------
   // Table storage: one write port shared by all operations.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bpt_pkg::TABLE_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (vld_we) begin
         valid_ff[tbl_wr_idx] <= vld_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we_addr) begin
         tbl_addr_ff[tbl_wr_idx] <= addr_ff;
      end
      if (tbl_we_rssi) begin
         tbl_rssi_ff[tbl_wr_idx] <= rssi_ff;
      end
      if (tbl_we_time) begin
         tbl_time_ff[tbl_wr_idx] <= tbl_wr_time;
      end
   end

   // ------------------------------------------------------------------
   // Response register. The paired address reads as zero unless the
   // table is paired to an address.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_present_ff   <= present_ff;
         rsp_close_ff     <= close_ff;
         rsp_count_ff     <= bpt_pkg::ENTRY_COUNT_W'(cnt_ff);
         rsp_pair_mode_ff <= pair_mode_ff;
         rsp_pair_addr_ff <= (pair_mode_ff == bpt_pkg::PAIR_ADDR) ? pair_addr_ff : '0;
         rsp_learning_ff  <= learn_ff;
         rsp_dropped_ff   <= dropped_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.present      = rsp_present_ff;
   assign rsp_bus.close        = rsp_close_ff;
   assign rsp_bus.entry_count  = rsp_count_ff;
   assign rsp_bus.pair_mode    = rsp_pair_mode_ff;
   assign rsp_bus.pair_address = rsp_pair_addr_ff;
   assign rsp_bus.learning     = rsp_learning_ff;
   assign rsp_bus.dropped      = rsp_dropped_ff;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the beacon presence table.
// Needs bpt_pkg, the bpt_*_if channel interfaces and beacon_presence_table.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // The slowest legal gap between two handshakes is both passes of the
   // sequencer plus a sender gap and a receiver stall. The limit is many
   // times that.
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 2 * bpt_pkg::TABLE_DEPTH + 8;
   localparam int POOL_SIZE = 20;
   localparam int PHASES = 6;

   // One status beat of the block, in the order of the response fields.
   typedef struct packed {
      logic                              present;
      logic                              close;
      logic [bpt_pkg::ENTRY_COUNT_W-1:0] count;
      bpt_pkg::pair_type                 mode;
      logic [bpt_pkg::ADDR_W-1:0]        mac;
      logic                              learning;
      logic                              dropped;
   } presence_type;

   // A row of the directed script. A row with reps above one repeats the
   // beat with the address counting up, which is how the table gets filled.
   typedef struct {
      bpt_pkg::op_type                   op;
      logic [bpt_pkg::TIME_W-1:0]        now;
      logic [bpt_pkg::ADDR_W-1:0]        mac;
      logic signed [bpt_pkg::RSSI_W-1:0] rssi;
      logic [bpt_pkg::TIME_W-1:0]        pause;
      int                                reps;
      bit                                typed;
      presence_type                      want;
   } script_row_type;

   localparam presence_type IDLE_VIEW = '{0, 0, 0, bpt_pkg::PAIR_OPEN, 0, 0, 0};

   logic clock = 1'b0;
   logic reset;

   bpt_req_if req_bus ();
   bpt_rsp_if rsp_bus ();
   bpt_csr_if csr_bus ();

   beacon_presence_table u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #10ns clock = ~clock;

   // Directed script, run from the reset register values (near -80, close -50,
   // timeout 30000). Rows with a typed status can be read straight off the
   // rules; the rest are checked against the table model below.
   script_row_type script [18] = '{
      // Finishing while not learning is ignored; aging an empty table is a no-op.
      '{bpt_pkg::OP_LEARN_FINISH, 32'h0, 48'h0, 8'sd0, 32'h0, 1, 1'b1, IDLE_VIEW},
      '{bpt_pkg::OP_AGE, 32'h0, 48'h0, 8'sd0, 32'h0, 1, 1'b1, IDLE_VIEW},
      // The weakest strength, and one exactly at the near threshold, are rejected.
      '{bpt_pkg::OP_REPORT, 32'h0, 48'hFFFF_FFFF_FFFF, 8'h80, 32'h0, 1, 1'b1, IDLE_VIEW},
      '{bpt_pkg::OP_REPORT, 32'h0, 48'h0, -8'sd80, 32'h0, 1, 1'b1, IDLE_VIEW},
      // Just above the threshold is recorded; the strongest report sets close.
      '{bpt_pkg::OP_REPORT, 32'h0, 48'h0, -8'sd79, 32'h0, 1, 1'b1,
        '{0, 0, 1, bpt_pkg::PAIR_OPEN, 0, 0, 0}},
      '{bpt_pkg::OP_REPORT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'sd127, 32'h0, 1, 1'b1,
        '{0, 1, 2, bpt_pkg::PAIR_OPEN, 0, 0, 0}},
      // A known address overwrites strength and time, at the close boundary.
      '{bpt_pkg::OP_REPORT, 32'd5, 48'hFFFF_FFFF_FFFF, -8'sd50, 32'h0, 1, 1'b0,
        IDLE_VIEW},
      // Shift every time by the largest pause so that they wrap, then purge:
      // one entry is just past the timeout, the other exactly at it.
      '{bpt_pkg::OP_AGE, 32'h0, 48'h0, 8'sd0, 32'hFFFF_FFFF, 1, 1'b0, IDLE_VIEW},
      '{bpt_pkg::OP_AGE, 32'd30004, 48'h0, 8'sd0, 32'h0, 1, 1'b0, IDLE_VIEW},
      // Begin twice, then fill the table; the last new address is dropped.
      '{bpt_pkg::OP_LEARN_BEGIN, 32'h0, 48'h0, 8'sd0, 32'h0, 2, 1'b0, IDLE_VIEW},
      '{bpt_pkg::OP_REPORT, 32'd100, 48'h5A5A_0000_0000, -8'sd60, 32'h0, 16, 1'b0,
        IDLE_VIEW},
      // Pair with the strongest, then try a stranger and a weak paired report.
      '{bpt_pkg::OP_LEARN_FINISH, 32'h0, 48'h0, 8'sd0, 32'h0, 1, 1'b0, IDLE_VIEW},
      '{bpt_pkg::OP_REPORT, 32'd200, 48'h5A5A_0000_0000, 8'sd0, 32'h0, 1, 1'b0,
        IDLE_VIEW},
      '{bpt_pkg::OP_REPORT, 32'd300, 48'hFFFF_FFFF_FFFF, -8'sd100, 32'h0, 1, 1'b0,
        IDLE_VIEW},
      // Purge everything, learn on an empty table and pair with nothing.
      '{bpt_pkg::OP_AGE, 32'h8000_0000, 48'h0, 8'sd0, 32'h0, 1, 1'b0, IDLE_VIEW},
      '{bpt_pkg::OP_LEARN_BEGIN, 32'h0, 48'h0, 8'sd0, 32'h0, 1, 1'b0, IDLE_VIEW},
      '{bpt_pkg::OP_LEARN_FINISH, 32'h0, 48'h0, 8'sd0, 32'h0, 1, 1'b0, IDLE_VIEW},
      // Paired to nothing and not learning, even a strong report is refused.
      '{bpt_pkg::OP_REPORT, 32'd400, 48'h0123_4567_89AB, 8'sd127, 32'h0, 1, 1'b0,
        IDLE_VIEW}
   };

   // Table model state and its copy of the registers.
   bit                                slot_used  [bpt_pkg::TABLE_DEPTH];
   logic [bpt_pkg::ADDR_W-1:0]        slot_mac   [bpt_pkg::TABLE_DEPTH];
   logic signed [bpt_pkg::RSSI_W-1:0] slot_rssi  [bpt_pkg::TABLE_DEPTH];
   logic [bpt_pkg::TIME_W-1:0]        slot_stamp [bpt_pkg::TABLE_DEPTH];
   bpt_pkg::pair_type                 pmode;
   logic [bpt_pkg::ADDR_W-1:0]        pmac;
   bit                                learn;
   logic signed [bpt_pkg::RSSI_W-1:0] near_db;
   logic signed [bpt_pkg::RSSI_W-1:0] close_db;
   logic [bpt_pkg::TIME_W-1:0]        stale_ms;

   // Status beats owed by the block, oldest first.
   presence_type status_due [$];

   // Random stimulus context.
   logic [bpt_pkg::ADDR_W-1:0]        mac_pool [POOL_SIZE];
   logic [bpt_pkg::TIME_W-1:0]        wall_ms;
   logic signed [bpt_pkg::RSSI_W-1:0] episode_rssi;
   bit                                gaps_on = 1'b1;

   int fail_count = 0;
   int beats = 0;
   int results = 0;
   int drops = 0;
   int sessions = 0;
   int quiet = 0;
   int stall_left = 0;
   int run_left = 0;

   // Applies one request to the table model and returns the status it yields.
   function automatic presence_type track_beacons(bpt_pkg::op_type op,
                                                  logic [bpt_pkg::TIME_W-1:0] now,
                                                  logic [bpt_pkg::ADDR_W-1:0] mac,
                                                  logic signed [bpt_pkg::RSSI_W-1:0] rssi,
                                                  logic [bpt_pkg::TIME_W-1:0] pause);
      presence_type               view;
      int                         hit;
      int                         free_slot;
      int                         best;
      logic [bpt_pkg::TIME_W-1:0] age;
      view = IDLE_VIEW;
      case (op)
         bpt_pkg::OP_REPORT: begin
            if (rssi > near_db &&
                (learn || pmode == bpt_pkg::PAIR_OPEN ||
                 (pmode == bpt_pkg::PAIR_ADDR && pmac == mac))) begin
               hit = -1;
               free_slot = -1;
               for (int i = 0; i < bpt_pkg::TABLE_DEPTH; i++) begin
                  if (slot_used[i] && slot_mac[i] == mac) hit = i;
                  if (!slot_used[i] && free_slot < 0) free_slot = i;
               end
               if (hit < 0 && free_slot < 0) begin
                  view.dropped = 1'b1;
               end else begin
                  if (hit < 0) begin
                     hit = free_slot;
                     slot_used[hit] = 1'b1;
                     slot_mac[hit] = mac;
                  end
                  slot_rssi[hit] = rssi;
                  slot_stamp[hit] = now;
               end
            end
         end
         bpt_pkg::OP_AGE: begin
            for (int i = 0; i < bpt_pkg::TABLE_DEPTH; i++) begin
               if (slot_used[i]) begin
                  age = now - slot_stamp[i];
                  if (pause != 0) slot_stamp[i] = slot_stamp[i] + pause;
                  else if (age > stale_ms) slot_used[i] = 1'b0;
               end
            end
         end
         bpt_pkg::OP_LEARN_BEGIN: begin
            learn = 1'b1;
         end
         default: begin
            if (learn) begin
               best = -1;
               for (int i = 0; i < bpt_pkg::TABLE_DEPTH; i++) begin
                  if (slot_used[i] && (best < 0 || slot_rssi[i] > slot_rssi[best] ||
                      (slot_rssi[i] == slot_rssi[best] && slot_mac[i] < slot_mac[best])))
                     best = i;
               end
               pmode = (best < 0) ? bpt_pkg::PAIR_EMPTY : bpt_pkg::PAIR_ADDR;
               pmac = (best < 0) ? '0 : slot_mac[best];
               learn = 1'b0;
            end
         end
      endcase
      for (int i = 0; i < bpt_pkg::TABLE_DEPTH; i++) begin
         if (slot_used[i]) begin
            view.count = view.count + 1'b1;
            if (slot_rssi[i] >= close_db) view.close = 1'b1;
            if (pmode == bpt_pkg::PAIR_ADDR && slot_mac[i] == pmac) view.present = 1'b1;
         end
      end
      view.mode = pmode;
      view.mac = (pmode == bpt_pkg::PAIR_ADDR) ? pmac : '0;
      view.learning = learn;
      return view;
   endfunction

   // Strengths lean toward what gets recorded, with the two thresholds and a
   // per-episode value mixed in so that strength ties show up when pairing.
   function automatic logic signed [bpt_pkg::RSSI_W-1:0] pick_rssi();
      int lo;
      int roll;
      int v;
      lo = near_db + 1;
      roll = $urandom_range(0, 9);
      if (roll < 2 || lo > 127) v = $urandom;
      else if (roll == 2) v = near_db;
      else if (roll == 3) v = close_db;
      else if (roll < 7) v = episode_rssi;
      else v = lo + $urandom_range(0, 127 - lo);
      return v[7:0];
   endfunction

   // Addresses mostly come from a pool a little larger than the table, so
   // that it fills, overwrites and drops; some are the paired address.
   function automatic logic [bpt_pkg::ADDR_W-1:0] pick_mac();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 3) return {16'($urandom), 32'($urandom)};
      if (roll < 6 && pmode == bpt_pkg::PAIR_ADDR) return pmac;
      return mac_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   task automatic log_mismatch(string field, logic [63:0] got, logic [63:0] want);
      fail_count++;
      if (fail_count <= 100)
         $display("status beat %0d: %s is %0h, model says %0h", results, field, got, want);
   endtask

   // Offers one request beat and, once it is taken, works out the status the
   // block owes for it. A typed status from the script takes the model's place.
   task automatic send_beat(bpt_pkg::op_type op, logic [bpt_pkg::TIME_W-1:0] now,
                            logic [bpt_pkg::ADDR_W-1:0] mac,
                            logic signed [bpt_pkg::RSSI_W-1:0] rssi,
                            logic [bpt_pkg::TIME_W-1:0] pause,
                            bit typed, presence_type typed_view);
      presence_type view;
      int           roll;
      @(negedge clock);
      roll = $urandom_range(0, 7);
      if (gaps_on && roll < 3) begin
         req_bus.valid <= 1'b0;
         // Sometimes the gap starts only once the block has gone idle.
         if (roll == 2) while (status_due.size() != 0) @(negedge clock);
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.now_ms <= now;
      req_bus.beacon_address <= mac;
      req_bus.beacon_strength <= rssi;
      req_bus.pause_ms <= pause;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (op == bpt_pkg::OP_LEARN_FINISH && learn) sessions++;
      view = track_beacons(op, now, mac, rssi, pause);
      status_due = {status_due, typed ? typed_view : view};
      if (view.dropped) drops++;
      beats++;
   endtask

   // Random request: time mostly creeps forward, now and then it jumps.
   task automatic random_beat(bpt_pkg::op_type op);
      logic [bpt_pkg::TIME_W-1:0] pause;
      int                         roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) wall_ms = $urandom;
      else wall_ms = wall_ms + $urandom_range(0, 3000);
      roll = $urandom_range(0, 9);
      if (roll < 5) pause = '0;
      else if (roll < 8) pause = $urandom_range(1, 5000);
      else pause = $urandom;
      send_beat(op, wall_ms, pick_mac(), pick_rssi(), pause, 1'b0, IDLE_VIEW);
   endtask

   task automatic write_reg(logic [bpt_pkg::CSR_IDX_W-1:0] idx,
                            logic [bpt_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         bpt_pkg::CSR_NEAR_THRESHOLD:  near_db = data[bpt_pkg::RSSI_W-1:0];
         bpt_pkg::CSR_CLOSE_THRESHOLD: close_db = data[bpt_pkg::RSSI_W-1:0];
         bpt_pkg::CSR_UNSEEN_TIMEOUT:  stale_ms = data;
         default: ;
      endcase
   endtask

   // Registers change only with the block idle: no request offered and every
   // owed status beat delivered. Each request yields a status, so nothing is
   // left running once the last one has been taken.
   task automatic reconfigure(int near_val, int close_val,
                              logic [bpt_pkg::TIME_W-1:0] stale_val);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (status_due.size() != 0) @(negedge clock);
      write_reg(bpt_pkg::CSR_NEAR_THRESHOLD, near_val);
      write_reg(bpt_pkg::CSR_CLOSE_THRESHOLD, close_val);
      write_reg(bpt_pkg::CSR_UNSEEN_TIMEOUT, stale_val);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Response side back-pressure: random stalls between runs of ready. Runs
   // are never empty, so every stall can be broken.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (run_left > 0) begin
         run_left = run_left - 1;
         rsp_bus.ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 2) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         run_left = $urandom_range(1, 30);
         rsp_bus.ready <= 1'b0;
      end else begin
         run_left = $urandom_range(1, 30);
         rsp_bus.ready <= 1'b1;
      end
   end

   // Every status beat taken is compared with the oldest one owed.
   always @(posedge clock) begin : status_check
      presence_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results++;
         if (status_due.size() == 0) begin
            log_mismatch("unexpected beat", 64'd1, 64'd0);
         end else begin
            want = status_due.pop_front();
            if (rsp_bus.present !== want.present)
               log_mismatch("present", rsp_bus.present, want.present);
            if (rsp_bus.close !== want.close)
               log_mismatch("close", rsp_bus.close, want.close);
            if (rsp_bus.entry_count !== want.count)
               log_mismatch("entry_count", rsp_bus.entry_count, want.count);
            if (rsp_bus.pair_mode !== want.mode)
               log_mismatch("pair_mode", rsp_bus.pair_mode, want.mode);
            if (rsp_bus.pair_address !== want.mac)
               log_mismatch("pair_address", rsp_bus.pair_address, want.mac);
            if (rsp_bus.learning !== want.learning)
               log_mismatch("learning", rsp_bus.learning, want.learning);
            if (rsp_bus.dropped !== want.dropped)
               log_mismatch("dropped", rsp_bus.dropped, want.dropped);
         end
      end
   end

   // Watchdog: too long without any handshake on any channel ends the run.
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
          (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
         quiet = 0;
      else
         quiet = quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("no handshake for %0d cycles, %0d status beats still owed",
                  QUIET_LIMIT, status_due.size());
         $display("beacon_presence_table regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int          phase_near  [PHASES];
      int          phase_close [PHASES];
      logic [31:0] phase_stale [PHASES];
      int          phase_beats [PHASES];
      int          directed_beats;
      int          target;
      int          kind;
      int          roll;

      // Every input is known from time zero.
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = bpt_pkg::OP_REPORT;
      req_bus.now_ms = '0;
      req_bus.beacon_address = '0;
      req_bus.beacon_strength = '0;
      req_bus.pause_ms = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = bpt_pkg::CSR_NEAR_THRESHOLD;
      csr_bus.data = '0;

      // Model state after reset.
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      pmode = bpt_pkg::PAIR_OPEN;
      pmac = '0;
      learn = 1'b0;
      near_db = bpt_pkg::NEAR_THRESHOLD_RST;
      close_db = bpt_pkg::CLOSE_THRESHOLD_RST;
      stale_ms = bpt_pkg::UNSEEN_TIMEOUT_RST;
      wall_ms = $urandom;
      foreach (mac_pool[i]) mac_pool[i] = {16'($urandom), 32'($urandom)};

      // Register settings: the extremes first (accept almost everything and
      // purge anything not seen this very millisecond; accept nothing and
      // never purge), then the reset values, then three random settings.
      phase_near  = '{-128, 127, -80, 0, 0, 0};
      phase_close = '{127, -128, -50, 0, 0, 0};
      phase_stale = '{32'd0, 32'hFFFF_FFFF, 32'd30000, 32'd0, 32'd0, 32'd0};
      phase_beats = '{140, 40, 150, 150, 150, 170};
      for (int p = 3; p < PHASES; p++) begin
         phase_near[p] = $urandom_range(0, 70) - 100;
         phase_close[p] = phase_near[p] + $urandom_range(0, 60);
         phase_stale[p] = $urandom_range(500, 60000);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[r])
         for (int k = 0; k < script[r].reps; k++)
            send_beat(script[r].op, script[r].now, script[r].mac + k, script[r].rssi,
                      script[r].pause, script[r].typed, script[r].want);
      directed_beats = beats;

      // Random part, in episodes. Learning sessions (begin, a burst of
      // reports, finish) carry most of the traffic since pairing only moves
      // through them; plain runs and scattered odd beats make up the rest.
      for (int p = 0; p < PHASES; p++) begin
         reconfigure(phase_near[p], phase_close[p], phase_stale[p]);
         // The final stretch runs flat out on both sides.
         if (p == PHASES - 1) gaps_on = 1'b0;
         target = beats + phase_beats[p];
         while (beats < target) begin
            kind = $urandom_range(0, 9);
            episode_rssi = pick_rssi();
            if (kind < 4) begin
               random_beat(bpt_pkg::OP_LEARN_BEGIN);
               repeat ($urandom_range(2, 20))
                  random_beat(($urandom_range(0, 9) == 0) ? bpt_pkg::OP_AGE :
                                                            bpt_pkg::OP_REPORT);
               random_beat(bpt_pkg::OP_LEARN_FINISH);
            end else if (kind < 9) begin
               repeat ($urandom_range(4, 16)) begin
                  roll = $urandom_range(0, 99);
                  random_beat(roll < 70 ? bpt_pkg::OP_REPORT :
                              roll < 90 ? bpt_pkg::OP_AGE :
                              roll < 95 ? bpt_pkg::OP_LEARN_FINISH :
                                          bpt_pkg::OP_LEARN_BEGIN);
               end
            end else begin
               repeat ($urandom_range(1, 4))
                  random_beat(bpt_pkg::op_type'($urandom_range(0, 3)));
            end
         end
      end

      // Let the owed beats come home, then watch a little longer for strays.
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d request beats (%0d scripted) over %0d register settings, %0d status beats",
               beats, directed_beats, PHASES, results);
      $display("%0d reports dropped on a full table, %0d learning sessions closed, %0d mismatches",
               drops, sessions, fail_count);
      if (fail_count == 0)
         $display("beacon_presence_table regression: pass");
      else
         $display("beacon_presence_table regression: fail");
      $finish;
   end

endmodule
